// ===== design/rdcd_pkg.sv =====
// Package with the shared types and constants of the remote drive command decoder.
`timescale 1ns / 1ps
`default_nettype none
package rdcd_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_STOPPED = 2'd1,
    MODE_REMOTE  = 2'd2
  } mode_t;

  localparam logic [7:0] CMD_PROP_UP    = 8'h01;
  localparam logic [7:0] CMD_PROP_DOWN  = 8'h02;
  localparam logic [7:0] CMD_DERIV_UP   = 8'h03;
  localparam logic [7:0] CMD_DERIV_DOWN = 8'h04;
  localparam logic [7:0] CMD_STOP       = 8'h05;
  localparam logic [7:0] CMD_REMOTE     = 8'h06;
  localparam logic [7:0] CMD_FASTER     = 8'h07;
  localparam logic [7:0] CMD_SLOWER     = 8'h08;
  localparam logic [7:0] CMD_LEFT       = 8'h09;
  localparam logic [7:0] CMD_RIGHT      = 8'h0a;
  localparam logic [7:0] CMD_HALT       = 8'h0b;
  localparam logic [7:0] CMD_REVERSE    = 8'h0c;

  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STEER_CENTER = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STEER_LEFT   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STEER_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPEED_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPEED_STEP   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STEER_STEP   = 3'd5;

  localparam int RST_STEER_CENTER = 8192;
  localparam int RST_STEER_LEFT   = 4096;
  localparam int RST_STEER_RIGHT  = 12288;
  localparam int RST_SPEED_LIMIT  = 8000;
  localparam int RST_SPEED_STEP   = 500;
  localparam int RST_STEER_STEP   = 200;

  localparam int GAIN_BITS = 16;
  localparam logic signed [GAIN_BITS-1:0] GAIN_MAX       = 16'sh7fff;
  localparam logic signed [GAIN_BITS-1:0] GAIN_MIN       = 16'sh8000;
  localparam logic signed [GAIN_BITS-1:0] RST_PROP_GAIN  = 16'sd20;
  localparam logic signed [GAIN_BITS-1:0] RST_DERIV_GAIN = 16'sd50;

  localparam int LED_BITS = 4;
  localparam logic [LED_BITS-1:0] LED_OFF       = 4'h0;
  localparam logic [LED_BITS-1:0] LED_ALL       = 4'hf;
  localparam logic [LED_BITS-1:0] LED_PAIR_PROP = 4'h3;
  localparam logic [LED_BITS-1:0] LED_PAIR_DER  = 4'hc;
  localparam logic [LED_BITS-1:0] LED_LEFT      = 4'h9;
  localparam logic [LED_BITS-1:0] LED_RIGHT     = 4'h6;

endpackage
`default_nettype wire

// ===== design/rdcd_cfg.sv =====
// Configuration register file of the remote drive command decoder.
`timescale 1ns / 1ps
`default_nettype none
module rdcd_cfg #(
  parameter int DUTY_BITS = 14
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [rdcd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [DUTY_BITS-1:0]               cfg_wdata,
  output logic [DUTY_BITS-1:0]                    steer_center,
  output logic [DUTY_BITS-1:0]                    steer_left_limit,
  output logic [DUTY_BITS-1:0]                    steer_right_limit,
  output logic [DUTY_BITS-1:0]                    speed_limit,
  output logic [DUTY_BITS-1:0]                    speed_step,
  output logic [DUTY_BITS-1:0]                    steer_step
);
  import rdcd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_center      <= DUTY_BITS'(RST_STEER_CENTER);
      steer_left_limit  <= DUTY_BITS'(RST_STEER_LEFT);
      steer_right_limit <= DUTY_BITS'(RST_STEER_RIGHT);
      speed_limit       <= DUTY_BITS'(RST_SPEED_LIMIT);
      speed_step        <= DUTY_BITS'(RST_SPEED_STEP);
      steer_step        <= DUTY_BITS'(RST_STEER_STEP);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEER_CENTER: steer_center      <= cfg_wdata;
        CFG_STEER_LEFT:   steer_left_limit  <= cfg_wdata;
        CFG_STEER_RIGHT:  steer_right_limit <= cfg_wdata;
        CFG_SPEED_LIMIT:  speed_limit       <= cfg_wdata;
        CFG_SPEED_STEP:   speed_step        <= cfg_wdata;
        CFG_STEER_STEP:   steer_step        <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/rdcd_update.sv =====
// Command state registers and the single-pass next-state logic for one command byte.
`timescale 1ns / 1ps
`default_nettype none
module rdcd_update #(
  parameter int DUTY_BITS = 14
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 fire,
  input  wire logic [7:0]                           rx_byte,
  input  wire logic [DUTY_BITS-1:0]                 steer_center,
  input  wire logic [DUTY_BITS-1:0]                 steer_left_limit,
  input  wire logic [DUTY_BITS-1:0]                 steer_right_limit,
  input  wire logic [DUTY_BITS-1:0]                 speed_limit,
  input  wire logic [DUTY_BITS-1:0]                 speed_step,
  input  wire logic [DUTY_BITS-1:0]                 steer_step,
  output rdcd_pkg::mode_t                           res_mode,
  output logic [DUTY_BITS-1:0]                      res_forward_duty,
  output logic [DUTY_BITS-1:0]                      res_reverse_duty,
  output logic [DUTY_BITS-1:0]                      res_steer_duty,
  output logic [rdcd_pkg::LED_BITS-1:0]             res_led_pattern,
  output logic signed [rdcd_pkg::GAIN_BITS-1:0]     res_prop_gain,
  output logic signed [rdcd_pkg::GAIN_BITS-1:0]     res_deriv_gain
);
  import rdcd_pkg::*;

  localparam int WIDE = DUTY_BITS + 2;

  mode_t                       mode_reg, mode_next;
  logic [DUTY_BITS-1:0]        speed_reg, speed_next;
  logic [DUTY_BITS-1:0]        steer_reg, steer_next;
  logic                        reverse_flag, reverse_next;
  logic [LED_BITS-1:0]         led_reg, led_next;
  logic signed [GAIN_BITS-1:0] prop_gain_reg, prop_next;
  logic signed [GAIN_BITS-1:0] deriv_gain_reg, deriv_next;

  logic signed [WIDE-1:0] spd_raw, str_raw, spd_hi, spd_clamp, str_clamp;
  logic [DUTY_BITS-1:0]   rem_speed, rem_steer;
  logic [LED_BITS-1:0]    rem_led;

  // Remote-mode arithmetic: step, then clamp in a signed range two bits wider.
  always_comb begin
    spd_raw = signed'({2'b00, speed_reg});
    str_raw = signed'({2'b00, steer_reg});
    unique case (rx_byte)
      CMD_FASTER: spd_raw = signed'({2'b00, speed_reg}) + signed'({2'b00, speed_step});
      CMD_SLOWER: spd_raw = signed'({2'b00, speed_reg}) - signed'({2'b00, speed_step});
      CMD_LEFT:   str_raw = signed'({2'b00, steer_reg}) - signed'({2'b00, steer_step});
      CMD_RIGHT:  str_raw = signed'({2'b00, steer_reg}) + signed'({2'b00, steer_step});
      CMD_HALT: begin
        spd_raw = '0;
        str_raw = signed'({2'b00, steer_center});
      end
      default: begin
      end
    endcase
    spd_hi = (spd_raw >= signed'({2'b00, speed_limit})) ? signed'({2'b00, speed_limit})
                                                        : spd_raw;
    spd_clamp = (spd_hi[WIDE-1] || spd_hi == '0) ? '0 : spd_hi;
    if (str_raw <= signed'({2'b00, steer_left_limit})) begin
      str_clamp = signed'({2'b00, steer_left_limit});
    end else if (str_raw >= signed'({2'b00, steer_right_limit})) begin
      str_clamp = signed'({2'b00, steer_right_limit});
    end else begin
      str_clamp = str_raw;
    end
    rem_speed = spd_clamp[DUTY_BITS-1:0];
    rem_steer = str_clamp[DUTY_BITS-1:0];
    if (rem_steer < steer_center) begin
      rem_led = LED_LEFT;
    end else if (rem_steer > steer_center) begin
      rem_led = LED_RIGHT;
    end else begin
      rem_led = led_reg;
    end
  end

  // Next state.
  always_comb begin
    mode_next    = mode_reg;
    speed_next   = speed_reg;
    steer_next   = steer_reg;
    reverse_next = reverse_flag;
    led_next     = led_reg;
    prop_next    = prop_gain_reg;
    deriv_next   = deriv_gain_reg;
    unique case (mode_reg)
      MODE_NORMAL: begin
        unique case (rx_byte)
          CMD_PROP_UP: begin
            if (prop_gain_reg != GAIN_MAX) prop_next = prop_gain_reg + 16'sd1;
            led_next = led_reg ^ LED_PAIR_PROP;
          end
          CMD_PROP_DOWN: begin
            if (prop_gain_reg != GAIN_MIN) prop_next = prop_gain_reg - 16'sd1;
            led_next = led_reg ^ LED_PAIR_PROP;
          end
          CMD_DERIV_UP: begin
            if (deriv_gain_reg != GAIN_MAX) deriv_next = deriv_gain_reg + 16'sd1;
            led_next = led_reg ^ LED_PAIR_DER;
          end
          CMD_DERIV_DOWN: begin
            if (deriv_gain_reg != GAIN_MIN) deriv_next = deriv_gain_reg - 16'sd1;
            led_next = led_reg ^ LED_PAIR_DER;
          end
          CMD_STOP: mode_next = MODE_STOPPED;
          CMD_REMOTE: begin
            mode_next    = MODE_REMOTE;
            speed_next   = '0;
            steer_next   = steer_center;
            reverse_next = 1'b0;
            led_next     = LED_ALL;
          end
          default: begin
          end
        endcase
      end
      MODE_STOPPED: begin
        if (rx_byte == CMD_STOP) begin
          mode_next = MODE_NORMAL;
        end else if (rx_byte == CMD_REMOTE) begin
          mode_next    = MODE_REMOTE;
          speed_next   = '0;
          steer_next   = steer_center;
          reverse_next = 1'b0;
          led_next     = LED_ALL;
        end
      end
      default: begin
        speed_next = rem_speed;
        steer_next = rem_steer;
        led_next   = rem_led;
        if (rx_byte == CMD_REVERSE) reverse_next = ~reverse_flag;
        if (rx_byte == CMD_REMOTE) begin
          led_next  = LED_OFF;
          mode_next = MODE_NORMAL;
        end
      end
    endcase
  end

  // Result fields follow the state after this item.
  always_comb begin
    res_mode         = mode_next;
    res_forward_duty = '0;
    res_reverse_duty = '0;
    res_steer_duty   = '0;
    res_led_pattern  = led_next;
    res_prop_gain    = prop_next;
    res_deriv_gain   = deriv_next;
    if (mode_next == MODE_REMOTE) begin
      if (reverse_next) begin
        res_reverse_duty = speed_next;
      end else begin
        res_forward_duty = speed_next;
      end
      res_steer_duty = steer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg       <= MODE_NORMAL;
      speed_reg      <= '0;
      steer_reg      <= DUTY_BITS'(RST_STEER_CENTER);
      reverse_flag   <= 1'b0;
      led_reg        <= LED_OFF;
      prop_gain_reg  <= RST_PROP_GAIN;
      deriv_gain_reg <= RST_DERIV_GAIN;
    end else if (fire) begin
      mode_reg       <= mode_next;
      speed_reg      <= speed_next;
      steer_reg      <= steer_next;
      reverse_flag   <= reverse_next;
      led_reg        <= led_next;
      prop_gain_reg  <= prop_next;
      deriv_gain_reg <= deriv_next;
    end
  end

  a_one_direction: assert property (@(posedge clk) disable iff (rst)
    fire |-> (res_forward_duty == '0 || res_reverse_duty == '0))
    else $error("forward and reverse duty both driven");

  a_gains_only_normal: assert property (@(posedge clk) disable iff (rst)
    fire && mode_reg != MODE_NORMAL |=> $stable(prop_gain_reg) && $stable(deriv_gain_reg))
    else $error("gain counter changed outside normal mode");

  a_remote_entry: assert property (@(posedge clk) disable iff (rst)
    fire && mode_reg != MODE_REMOTE && rx_byte != CMD_REMOTE |=> mode_reg != MODE_REMOTE)
    else $error("remote mode entered without its command");

endmodule
`default_nettype wire

// ===== design/remote_drive_command_decoder.sv =====
// Top level of the remote drive command decoder: input stage, update logic and result register.
// A command byte taken into the input register reaches the result register when it can advance.
// Throughput: one byte per cycle while the result is not stalled; the input and the result
// registers form a two-stage pipeline; the single state update between them sets that figure.
// A stalled result holds while the input register still takes one more byte.
// Synchronous reset returns the mode to normal, all LEDs off, gains 20 and 50, and
// every configuration register to its default.
`timescale 1ns / 1ps
`default_nettype none
module remote_drive_command_decoder #(
  parameter int DUTY_BITS = 14
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [7:0]                        s_tdata,   // rx_byte
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // mode, forward_duty, reverse_duty, steer_duty, led_pattern, prop_gain, deriv_gain, zero pad
  output logic [((38 + 3 * DUTY_BITS + 7) / 8) * 8 - 1:0] m_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [rdcd_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [DUTY_BITS-1:0]              cfg_wdata
);
  import rdcd_pkg::*;

  localparam int OUT_BITS = 38 + 3 * DUTY_BITS;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  logic                        in_valid;
  logic [7:0]                  in_byte;
  logic                        advance;
  logic                        fire;
  logic [DUTY_BITS-1:0]        steer_center, steer_left_limit, steer_right_limit;
  logic [DUTY_BITS-1:0]        speed_limit, speed_step, steer_step;
  mode_t                       res_mode;
  logic [DUTY_BITS-1:0]        res_forward_duty, res_reverse_duty, res_steer_duty;
  logic [LED_BITS-1:0]         res_led_pattern;
  logic signed [GAIN_BITS-1:0] res_prop_gain, res_deriv_gain;
  logic [OUT_BITS-1:0]         packed_res;

  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  rdcd_cfg #(.DUTY_BITS(DUTY_BITS)) u_cfg (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .steer_center      (steer_center),
    .steer_left_limit  (steer_left_limit),
    .steer_right_limit (steer_right_limit),
    .speed_limit       (speed_limit),
    .speed_step        (speed_step),
    .steer_step        (steer_step)
  );

  rdcd_update #(.DUTY_BITS(DUTY_BITS)) u_update (
    .clk               (clk),
    .rst               (rst),
    .fire              (fire),
    .rx_byte           (in_byte),
    .steer_center      (steer_center),
    .steer_left_limit  (steer_left_limit),
    .steer_right_limit (steer_right_limit),
    .speed_limit       (speed_limit),
    .speed_step        (speed_step),
    .steer_step        (steer_step),
    .res_mode          (res_mode),
    .res_forward_duty  (res_forward_duty),
    .res_reverse_duty  (res_reverse_duty),
    .res_steer_duty    (res_steer_duty),
    .res_led_pattern   (res_led_pattern),
    .res_prop_gain     (res_prop_gain),
    .res_deriv_gain    (res_deriv_gain)
  );

  assign packed_res = {res_deriv_gain, res_prop_gain, res_led_pattern, res_steer_duty,
                       res_reverse_duty, res_forward_duty, res_mode};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= OUT_W'(packed_res);
    end
  end

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input stage empty but not ready");

  a_fire_shows: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("processed item did not reach the result register");

  a_held_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte))
    else $error("waiting item lost from the input stage");

endmodule
`default_nettype wire

// ===== tb/remote_drive_command_decoder_test.sv =====
// Self-checking testbench of the remote drive command decoder: directed table and random streams.
`timescale 1ns / 1ps
module remote_drive_command_decoder_test;
  import rdcd_pkg::*;

  localparam int DUTY_BITS = 14;
  localparam int DUTY_MAX = (1 << DUTY_BITS) - 1;
  localparam int QUIET_LIMIT = 1000;
  localparam int ITEMS_PER_PHASE = 120;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;

  typedef logic [DUTY_BITS-1:0] duty_t;

  // Declared from the top bit down, so mode sits in the lowest bits of tdata.
  typedef struct packed {
    logic signed [GAIN_BITS-1:0] deriv_gain;
    logic signed [GAIN_BITS-1:0] prop_gain;
    logic [LED_BITS-1:0]         led_pattern;
    duty_t                       steer_duty;
    duty_t                       reverse_duty;
    duty_t                       forward_duty;
    mode_t                       mode;
  } drive_result_t;

  typedef struct {
    logic [7:0]    cmd;
    bit            typed;
    drive_result_t want;
  } cmd_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [$bits(drive_result_t)-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  duty_t cfg_wdata = '0;

  cmd_item_t command_q[$];
  drive_result_t expected_q[$];
  int errors = 0;
  int quiet_cycles = 0;
  int hold_cycles = 0;
  bit steady = 1'b0;
  int burst_left = 0;
  int pace_left = 0;
  bit pace_ready = 1'b0;

  // Shadow copy of the decoder state and its settings.
  int reg_val[6];
  mode_t pr_mode;
  int pr_speed;
  int pr_steer;
  bit pr_reverse;
  logic [LED_BITS-1:0] pr_leds;
  int pr_prop;
  int pr_deriv;

  remote_drive_command_decoder #(.DUTY_BITS(DUTY_BITS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic reset_shadow();
    reg_val[CFG_STEER_CENTER] = RST_STEER_CENTER;
    reg_val[CFG_STEER_LEFT] = RST_STEER_LEFT;
    reg_val[CFG_STEER_RIGHT] = RST_STEER_RIGHT;
    reg_val[CFG_SPEED_LIMIT] = RST_SPEED_LIMIT;
    reg_val[CFG_SPEED_STEP] = RST_SPEED_STEP;
    reg_val[CFG_STEER_STEP] = RST_STEER_STEP;
    pr_mode = MODE_NORMAL;
    pr_speed = 0;
    pr_steer = RST_STEER_CENTER;
    pr_reverse = 1'b0;
    pr_leds = LED_OFF;
    pr_prop = int'(RST_PROP_GAIN);
    pr_deriv = int'(RST_DERIV_GAIN);
  endtask

  function automatic int saturate_gain(input int gain, input int delta);
    int sum;
    sum = gain + delta;
    if (sum > int'(GAIN_MAX)) sum = int'(GAIN_MAX);
    if (sum < int'(GAIN_MIN)) sum = int'(GAIN_MIN);
    return sum;
  endfunction

  function automatic void start_remote();
    pr_mode = MODE_REMOTE;
    pr_speed = 0;
    pr_steer = reg_val[CFG_STEER_CENTER];
    pr_reverse = 1'b0;
    pr_leds = LED_ALL;
  endfunction

  function automatic drive_result_t decode_command(input logic [7:0] cmd);
    drive_result_t res;
    int spd;
    int str;
    bit leave;
    case (pr_mode)
      MODE_NORMAL: begin
        case (cmd)
          CMD_PROP_UP: begin
            pr_prop = saturate_gain(pr_prop, 1);
            pr_leds ^= LED_PAIR_PROP;
          end
          CMD_PROP_DOWN: begin
            pr_prop = saturate_gain(pr_prop, -1);
            pr_leds ^= LED_PAIR_PROP;
          end
          CMD_DERIV_UP: begin
            pr_deriv = saturate_gain(pr_deriv, 1);
            pr_leds ^= LED_PAIR_DER;
          end
          CMD_DERIV_DOWN: begin
            pr_deriv = saturate_gain(pr_deriv, -1);
            pr_leds ^= LED_PAIR_DER;
          end
          CMD_STOP: pr_mode = MODE_STOPPED;
          CMD_REMOTE: start_remote();
          default: ;
        endcase
      end
      MODE_STOPPED: begin
        if (cmd == CMD_STOP) pr_mode = MODE_NORMAL;
        else if (cmd == CMD_REMOTE) start_remote();
      end
      default: begin
        spd = pr_speed;
        str = pr_steer;
        leave = 1'b0;
        case (cmd)
          CMD_REMOTE: leave = 1'b1;
          CMD_FASTER: spd += reg_val[CFG_SPEED_STEP];
          CMD_SLOWER: spd -= reg_val[CFG_SPEED_STEP];
          CMD_LEFT: str -= reg_val[CFG_STEER_STEP];
          CMD_RIGHT: str += reg_val[CFG_STEER_STEP];
          CMD_HALT: begin
            spd = 0;
            str = reg_val[CFG_STEER_CENTER];
          end
          CMD_REVERSE: pr_reverse = !pr_reverse;
          default: ;
        endcase
        if (spd >= reg_val[CFG_SPEED_LIMIT]) spd = reg_val[CFG_SPEED_LIMIT];
        if (spd <= 0) spd = 0;
        if (str <= reg_val[CFG_STEER_LEFT]) str = reg_val[CFG_STEER_LEFT];
        else if (str >= reg_val[CFG_STEER_RIGHT]) str = reg_val[CFG_STEER_RIGHT];
        pr_speed = spd & DUTY_MAX;
        pr_steer = str & DUTY_MAX;
        if (pr_steer < reg_val[CFG_STEER_CENTER]) pr_leds = LED_LEFT;
        else if (pr_steer > reg_val[CFG_STEER_CENTER]) pr_leds = LED_RIGHT;
        if (leave) begin
          pr_leds = LED_OFF;
          pr_mode = MODE_NORMAL;
        end
      end
    endcase
    res = '0;
    res.mode = pr_mode;
    if (pr_mode == MODE_REMOTE) begin
      if (pr_reverse) res.reverse_duty = duty_t'(pr_speed);
      else res.forward_duty = duty_t'(pr_speed);
      res.steer_duty = duty_t'(pr_steer);
    end
    res.led_pattern = pr_leds;
    res.prop_gain = GAIN_BITS'(pr_prop);
    res.deriv_gain = GAIN_BITS'(pr_deriv);
    return res;
  endfunction

  task automatic add_cmd(input logic [7:0] cmd);
    cmd_item_t item;
    item.cmd = cmd;
    item.typed = 1'b0;
    item.want = '0;
    command_q.push_back(item);
  endtask

  task automatic add_row(input logic [7:0] cmd, input mode_t md, input int fwd, input int rev,
                         input int steer, input logic [LED_BITS-1:0] leds, input int prop,
                         input int deriv);
    cmd_item_t item;
    item.cmd = cmd;
    item.typed = 1'b1;
    item.want.mode = md;
    item.want.forward_duty = duty_t'(fwd);
    item.want.reverse_duty = duty_t'(rev);
    item.want.steer_duty = duty_t'(steer);
    item.want.led_pattern = leds;
    item.want.prop_gain = GAIN_BITS'(prop);
    item.want.deriv_gain = GAIN_BITS'(deriv);
    command_q.push_back(item);
  endtask

  function automatic logic [7:0] pick_normal();
    case ($urandom_range(0, 9))
      0: return CMD_PROP_UP;
      1: return CMD_PROP_DOWN;
      2: return CMD_DERIV_UP;
      3: return CMD_DERIV_DOWN;
      4: return CMD_PROP_UP;
      5: return CMD_DERIV_DOWN;
      6, 7: return CMD_STOP;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_remote();
    case ($urandom_range(0, 11))
      0, 1: return CMD_FASTER;
      2, 3: return CMD_SLOWER;
      4, 5: return CMD_LEFT;
      6, 7: return CMD_RIGHT;
      8: return CMD_HALT;
      9: return CMD_REVERSE;
      10: return CMD_DERIV_UP;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_sessions();
    while (command_q.size() < ITEMS_PER_PHASE) begin
      repeat ($urandom_range(0, 6)) add_cmd(pick_normal());
      add_cmd(CMD_REMOTE);
      repeat ($urandom_range(1, 30)) add_cmd(pick_remote());
      if ($urandom_range(0, 9) != 0) add_cmd(CMD_REMOTE);
    end
  endtask

  task automatic send_commands();
    cmd_item_t item;
    drive_result_t res;
    int gap;
    while (command_q.size() != 0) begin
      if (burst_left == 0) begin
        if (!steady) begin
          gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 3);
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = steady ? 1 << 30 : $urandom_range(1, 30);
      end
      item = command_q[0];
      s_tvalid <= 1'b1;
      s_tdata <= item.cmd;
      do @(posedge clk); while (!s_tready);
      void'(command_q.pop_front());
      res = decode_command(item.cmd);
      expected_q.push_back(item.typed ? item.want : res);
      burst_left--;
    end
    s_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(input int center, input int left, input int right,
                               input int limit, input int spd_step, input int str_step);
    int vals[6];
    vals[CFG_STEER_CENTER] = center;
    vals[CFG_STEER_LEFT] = left;
    vals[CFG_STEER_RIGHT] = right;
    vals[CFG_SPEED_LIMIT] = limit;
    vals[CFG_SPEED_STEP] = spd_step;
    vals[CFG_STEER_STEP] = str_step;
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_BITS'(i);
      cfg_wdata <= duty_t'(vals[i]);
      @(posedge clk);
      reg_val[i] = vals[i] & DUTY_MAX;
    end
    // Writes beyond the register list must leave every setting alone.
    cfg_index <= $urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI;
    cfg_wdata <= duty_t'($urandom_range(0, DUTY_MAX));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase();
    queue_sessions();
    send_commands();
    drain();
  endtask

  task automatic report(input string field, input int want, input int got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    drive_result_t got;
    drive_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = drive_result_t'(m_tdata);
      if (expected_q.size() == 0) begin
        $display("%0t ns: result with nothing expected, got %h", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.mode !== want.mode) report("mode", want.mode, got.mode);
        if (got.forward_duty !== want.forward_duty)
          report("forward_duty", want.forward_duty, got.forward_duty);
        if (got.reverse_duty !== want.reverse_duty)
          report("reverse_duty", want.reverse_duty, got.reverse_duty);
        if (got.steer_duty !== want.steer_duty)
          report("steer_duty", want.steer_duty, got.steer_duty);
        if (got.led_pattern !== want.led_pattern)
          report("led_pattern", want.led_pattern, got.led_pattern);
        if (got.prop_gain !== want.prop_gain) report("prop_gain", want.prop_gain, got.prop_gain);
        if (got.deriv_gain !== want.deriv_gain)
          report("deriv_gain", want.deriv_gain, got.deriv_gain);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_tready <= 1'b0;
    end else if (steady) begin
      m_tready <= 1'b1;
    end else begin
      if (pace_left == 0) begin
        pace_ready = !pace_ready;
        if (pace_ready) pace_left = $urandom_range(1, 40);
        else pace_left = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 3);
      end
      pace_left--;
      m_tready <= pace_ready;
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("remote_drive_command_decoder_test: done, errors");
      $finish;
    end
  end

  initial begin
    int center;
    reset_shadow();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_row(CMD_PROP_UP, MODE_NORMAL, 0, 0, 0, LED_PAIR_PROP, 21, 50);
    add_row(CMD_PROP_DOWN, MODE_NORMAL, 0, 0, 0, LED_OFF, 20, 50);
    add_row(CMD_DERIV_UP, MODE_NORMAL, 0, 0, 0, LED_PAIR_DER, 20, 51);
    add_row(CMD_DERIV_DOWN, MODE_NORMAL, 0, 0, 0, LED_OFF, 20, 50);
    add_row(8'hff, MODE_NORMAL, 0, 0, 0, LED_OFF, 20, 50);
    add_row(8'h00, MODE_NORMAL, 0, 0, 0, LED_OFF, 20, 50);
    add_row(CMD_STOP, MODE_STOPPED, 0, 0, 0, LED_OFF, 20, 50);
    add_row(CMD_PROP_UP, MODE_STOPPED, 0, 0, 0, LED_OFF, 20, 50);
    add_row(CMD_STOP, MODE_NORMAL, 0, 0, 0, LED_OFF, 20, 50);
    add_row(CMD_STOP, MODE_STOPPED, 0, 0, 0, LED_OFF, 20, 50);
    add_row(CMD_REMOTE, MODE_REMOTE, 0, 0, 8192, LED_ALL, 20, 50);
    add_row(CMD_FASTER, MODE_REMOTE, 500, 0, 8192, LED_ALL, 20, 50);
    add_row(CMD_REVERSE, MODE_REMOTE, 0, 500, 8192, LED_ALL, 20, 50);
    add_row(CMD_LEFT, MODE_REMOTE, 0, 500, 7992, LED_LEFT, 20, 50);
    add_cmd(CMD_RIGHT);
    add_cmd(CMD_RIGHT);
    add_row(CMD_HALT, MODE_REMOTE, 0, 0, 8192, LED_RIGHT, 20, 50);
    add_row(CMD_SLOWER, MODE_REMOTE, 0, 0, 8192, LED_RIGHT, 20, 50);
    add_cmd(CMD_PROP_UP);
    add_cmd(8'h80);
    add_row(CMD_REMOTE, MODE_NORMAL, 0, 0, 0, LED_OFF, 20, 50);
    add_row(CMD_REMOTE, MODE_REMOTE, 0, 0, 8192, LED_ALL, 20, 50);
    add_cmd(CMD_REVERSE);
    add_row(CMD_REMOTE, MODE_NORMAL, 0, 0, 0, LED_OFF, 20, 50);
    send_commands();
    drain();

    // Back-to-back gain commands with the output side always ready.
    steady = 1'b1;
    repeat (10) begin
      add_cmd(CMD_PROP_UP);
      add_cmd(CMD_DERIV_DOWN);
    end
    repeat (10) begin
      add_cmd(CMD_PROP_DOWN);
      add_cmd(CMD_DERIV_UP);
    end
    send_commands();
    drain();
    steady = 1'b0;
    burst_left = 0;

    // The output side holds off long enough for the pipeline to back up.
    hold_cycles = 80;
    random_phase();

    load_settings(0, 0, 0, 0, 0, 0);
    random_phase();
    load_settings(DUTY_MAX, DUTY_MAX, DUTY_MAX, DUTY_MAX, DUTY_MAX, DUTY_MAX);
    random_phase();
    load_settings(8000, 9000, 7000, DUTY_MAX, DUTY_MAX, 3000);
    random_phase();
    load_settings(100, 0, DUTY_MAX, 900, 300, 40);
    random_phase();
    repeat (4) begin
      center = $urandom_range(0, DUTY_MAX);
      load_settings(center, $urandom_range(0, center), $urandom_range(center, DUTY_MAX),
                    $urandom_range(0, DUTY_MAX), $urandom_range(0, 3000),
                    $urandom_range(0, 3000));
      random_phase();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("remote_drive_command_decoder_test: done, clean");
    end else begin
      $display("remote_drive_command_decoder_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/rdcd_pkg.sv
design/rdcd_cfg.sv
design/rdcd_update.sv
design/remote_drive_command_decoder.sv
tb/remote_drive_command_decoder_test.sv
